>>> hdl/mfd_pkg.sv
// Meter frame decoder package: transaction types, frame layout constants,
// CRC-16 byte update and descramble key selection.
// No dependencies.
package mfd_pkg;

	typedef logic [4:0] idx_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_item_t;

	typedef struct packed {
		logic        header_ok;
		logic        crc_error;
		logic [15:0] sequence_res;
		logic [15:0] power_raw;
		logic [31:0] pulse_total;
		logic [7:0]  battery_level;
		logic [7:0]  mode_code;
	} res_item_t;

	localparam logic [15:0] CRC_POLY   = 16'h8005;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [31:0] KEY_OFFSET = 32'h5D38E8CB;
	localparam logic [7:0]  KEY_FILL   = 8'h47;
	localparam logic [7:0]  SYNC_BYTE  = 8'h11;
	localparam logic [7:0]  VERSION    = 8'h07;
	localparam logic [7:0]  MODE_MASK  = 8'h0F;

	// byte positions within the frame
	localparam idx_t IDX_SYNC      = 5'd0;
	localparam idx_t IDX_ID_LO     = 5'd1;
	localparam idx_t IDX_VER       = 5'd3;
	localparam idx_t IDX_MODE      = 5'd4;
	localparam idx_t IDX_ID_FIRST  = 5'd5;
	localparam idx_t IDX_ID_LAST   = 5'd8;
	localparam idx_t IDX_FLD_FIRST = 5'd9;
	localparam idx_t IDX_FLD_LAST  = 5'd16;
	localparam idx_t IDX_BATT      = 5'd17;
	localparam idx_t IDX_CRC_HI    = 5'd18;
	localparam idx_t IDX_LAST      = 5'd19;
	localparam idx_t IDX_IDLE      = 5'd20;

	// MSB-first CRC-16, eight bit steps per byte
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		logic        top;
		r = c;
		for (int i = 0; i < 8; i++) begin
			top = r[15] ^ d[7 - i];
			r   = {r[14:0], 1'b0};
			if (top) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// key entry (p - 5) mod 5 over (k[31:24], k[7:0], k[15:8], 0x47, k[23:16])
	function automatic logic [7:0] key_byte(input logic [31:0] k, input idx_t p);
		logic [7:0] kb;
		unique case (p)
			5'd5, 5'd10, 5'd15: kb = k[31:24];
			5'd6, 5'd11, 5'd16: kb = k[7:0];
			5'd7, 5'd12, 5'd17: kb = k[15:8];
			5'd8, 5'd13:        kb = KEY_FILL;
			5'd9, 5'd14:        kb = k[23:16];
			default:            kb = 8'h00;
		endcase
		return kb;
	endfunction

endpackage

>>> hdl/meter_frame_decoder_top.sv
// Meter frame decoder top level: byte input register, frame state update,
// result output register. Depends on mfd_pkg.
//
// Usage:
//   rx channel (rx_valid / rx_stall / rx_item) carries one frame byte per
//   transaction; frame_start marks byte 0 and drops any partial frame.
//   res channel (res_valid / res_stall / res_item) carries one decoded
//   result after byte 19 of each frame: header check, CRC check and fields.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the node id; it is
//   always ready. The user must write it only while the block is idle (not enforced).
// Timing:
//   One byte per cycle sustained while rx_stall is low. A byte is held in the input
//   register; the CRC byte update, descramble and header check run in the
//   single logic stage after it, and the result of byte 19 is then loaded
//   into the result register, unless rx_stall holds that byte back.
// Reset clears the frame state (index 0, CRC 0xFFFF) and the node id to zero;
// the first byte after reset counts as byte 0 even without frame_start.
// While the result register is full and stalled, bytes keep flowing; only a
// byte that would complete a frame waits, and then rx_stall rises.
module meter_frame_decoder_top
	import mfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rx_valid,
	output logic      rx_stall,
	input  rx_item_t  rx_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] node_id_q;

	logic       valid_s1;
	rx_item_t   item_s1;

	idx_t        idx_q;
	logic [15:0] crc_q;
	logic        hdr_q;
	logic [31:0] id_q;
	logic [63:0] fld_q;
	logic [7:0]  mode_q;
	logic [7:0]  batt_q;
	logic [7:0]  crc_hi_q;

	logic        res_valid_q;
	res_item_t   res_item_q;

	idx_t        p;
	logic [15:0] crc_base;
	logic        hdr_base;
	logic        live;
	logic        last;
	logic [7:0]  d;
	logic [31:0] key;
	logic        blocked;
	logic        step;
	logic [15:0] crc_next;
	logic        hdr_next;
	idx_t        idx_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_id_q <= cfg_data;
		end
	end

	// frame_start restarts the frame on this byte
	always_comb begin
		p        = item_s1.frame_start ? IDX_SYNC : idx_q;
		crc_base = item_s1.frame_start ? CRC_INIT : crc_q;
		hdr_base = item_s1.frame_start ? 1'b1 : hdr_q;
		live     = (p < IDX_IDLE);
		last     = live && (p == IDX_LAST);
		key      = node_id_q - KEY_OFFSET;
		d        = (p >= IDX_ID_FIRST && p <= IDX_BATT) ?
			(item_s1.rx_byte ^ key_byte(key, p)) : item_s1.rx_byte;

		crc_next = (live && p < IDX_CRC_HI) ? crc_byte(crc_base, item_s1.rx_byte) : crc_base;

		hdr_next = hdr_base;
		if (live) begin
			priority if (p == IDX_SYNC && d != SYNC_BYTE) hdr_next = 1'b0;
			else if (p == IDX_ID_LO && d != node_id_q[7:0]) hdr_next = 1'b0;
			else if (p == IDX_VER && d != VERSION) hdr_next = 1'b0;
			else if (p == IDX_ID_LAST && {id_q[23:0], d} != node_id_q) hdr_next = 1'b0;
			else hdr_next = hdr_base;
		end

		if (!live) begin
			idx_next = p;
		end else if (last) begin
			idx_next = IDX_IDLE;
		end else begin
			idx_next = idx_t'(p + 5'd1);
		end

		blocked = valid_s1 && last && res_valid_q && res_stall;
		step    = valid_s1 && !blocked;
	end

	assign rx_stall = blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			item_s1 <= rx_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= IDX_SYNC;
			crc_q <= CRC_INIT;
			hdr_q <= 1'b1;
		end else if (step) begin
			idx_q <= idx_next;
			crc_q <= crc_next;
			hdr_q <= hdr_next;
		end
	end

	// field bytes are all rewritten by every complete frame
	always_ff @(posedge clk) begin
		if (step && live) begin
			if (p == IDX_MODE) begin
				mode_q <= d ^ MODE_MASK;
			end
			if (p >= IDX_ID_FIRST && p <= IDX_ID_LAST) begin
				id_q <= {id_q[23:0], d};
			end
			if (p >= IDX_FLD_FIRST && p <= IDX_FLD_LAST) begin
				fld_q <= {fld_q[55:0], d};
			end
			if (p == IDX_BATT) begin
				batt_q <= d;
			end
			if (p == IDX_CRC_HI) begin
				crc_hi_q <= d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) begin
			res_item_q.header_ok     <= hdr_base;
			res_item_q.crc_error     <= ({crc_hi_q, d} != crc_base);
			res_item_q.sequence_res  <= fld_q[63:48];
			res_item_q.power_raw     <= fld_q[47:32];
			res_item_q.pulse_total   <= fld_q[31:0];
			res_item_q.battery_level <= batt_q;
			res_item_q.mode_code     <= mode_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

>>> hdl/mfd_checker.sv
// Port-level checker for the meter frame decoder, bound to the top level.
// Depends on mfd_pkg and meter_frame_decoder_top.
module mfd_checker
	import mfd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rx_stall,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res_item,
	input logic      cfg_ready
);

	// a stalled result transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// input only backs up behind a full, stalled result register
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall)
		else $error("rx_stall without a stalled result");

	// results are a frame apart, so a drained result never stalls the next byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall |=> !rx_stall)
		else $error("rx_stall right after a result transaction");

	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg_ready dropped");

endmodule

bind meter_frame_decoder_top mfd_checker u_mfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_stall  (rx_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item),
	.cfg_ready (cfg_ready)
);
